// ===== sv/shtqp_pkg.sv =====
// Shared types and constants for the string hash table.
`timescale 1ns / 1ps
package shtqp_pkg;
  localparam int SLOTS = 256;
  localparam int MAX_KEY_LEN = 20;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LEN_W = 5;
  localparam int CHAR_W = 7;
  localparam int KEY_ADDR_W = $clog2(SLOTS * MAX_KEY_LEN);
  localparam int QIDX_W = $clog2(MAX_KEY_LEN);

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_FOUND = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_HASH_MULT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_MOD, S_PROBE, S_READ, S_CHECK,
    S_CMP, S_WRITE, S_NEXT, S_DONE
  } state_t;

  typedef struct packed {
    logic acc_char;
    logic acc_mul;
    logic acc_add;
    logic mod_start;
    logic probe_init;
    logic probe_step;
    logic slot_read;
    logic cmp_init;
    logic cmp_step;
    logic write_step;
    logic clear_query;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic op;
    logic too_long;
    logic mod_done;
    logic probes_left;
    logic used;
    logic len_match;
    logic cmp_left;
    logic char_match;
    logic write_left;
  } stat_t;
endpackage

// ===== sv/shtqp_datapath.sv =====
// Datapath: hash accumulator, modulo unit, probe sequence, key memories.
`timescale 1ns / 1ps
module shtqp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [8:0]          table_size,
  input  logic [31:0]         hash_multiplier,
  input  logic                op,
  input  logic [6:0]          key_char,
  input  logic                last_char,
  input  shtqp_pkg::cmd_t     cmd,
  output shtqp_pkg::stat_t    stat,
  output logic [7:0]          slot_out
);
  logic [31:0] hash;
  logic [31:0] product;
  logic [6:0] char_hold;
  logic last_hold, op_hold;
  logic [shtqp_pkg::LEN_W-1:0] qlen;
  logic [6:0] query [shtqp_pkg::MAX_KEY_LEN];
  logic [8:0] size;
  // restoring division remainder, one bit a cycle
  logic [8:0] rem;
  logic [31:0] dividend;
  logic [5:0] mod_cnt;
  logic [8:0] slot, step;
  logic [8:0] probe_cnt;
  logic [shtqp_pkg::SLOTS-1:0] used;
  logic [shtqp_pkg::LEN_W-1:0] len_mem [shtqp_pkg::SLOTS];
  logic [6:0] key_mem [shtqp_pkg::SLOTS * shtqp_pkg::MAX_KEY_LEN];
  logic [shtqp_pkg::LEN_W-1:0] len_rd;
  logic [6:0] key_rd;
  logic [shtqp_pkg::LEN_W-1:0] ci;
  logic [9:0] rem_sh, sum1, sum2;
  logic [shtqp_pkg::KEY_ADDR_W-1:0] key_addr;

  assign size = (table_size == 9'd0) ? 9'd1 :
                (table_size > 9'(shtqp_pkg::SLOTS)) ? 9'(shtqp_pkg::SLOTS) : table_size;
  assign rem_sh = {rem, dividend[31]};
  assign key_addr = shtqp_pkg::KEY_ADDR_W'(slot[shtqp_pkg::SLOT_W-1:0]
                    * shtqp_pkg::MAX_KEY_LEN + ci);
  assign sum1 = {1'b0, slot} + {1'b0, step};
  assign sum2 = {1'b0, step} + 10'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= '0;
      qlen <= '0;
      used <= '0;
    end else begin
      if (cmd.acc_char) begin
        char_hold <= key_char;
        last_hold <= last_char;
        op_hold <= op;
        if (qlen < shtqp_pkg::LEN_W'(shtqp_pkg::MAX_KEY_LEN))
          query[qlen[shtqp_pkg::QIDX_W-1:0]] <= key_char;
        if (qlen <= shtqp_pkg::LEN_W'(shtqp_pkg::MAX_KEY_LEN)) qlen <= qlen + 1'b1;
      end
      if (cmd.acc_mul) product <= hash * hash_multiplier;
      if (cmd.acc_add) hash <= product + 32'(char_hold);
      if (cmd.mod_start) begin
        dividend <= hash;
        rem <= '0;
        mod_cnt <= 6'd32;
      end else if (mod_cnt != 6'd0) begin
        rem <= (rem_sh >= {1'b0, size}) ? 9'(rem_sh - {1'b0, size}) : rem_sh[8:0];
        dividend <= {dividend[30:0], 1'b0};
        mod_cnt <= mod_cnt - 1'b1;
      end
      if (cmd.probe_init) begin
        slot <= rem;
        step <= 9'd1;
        probe_cnt <= size;
      end else if (cmd.probe_step) begin
        // next offset grows by i+1: running sum mod size
        slot <= 9'((sum1 >= {1'b0, size}) ? sum1 - {1'b0, size} : sum1);
        step <= 9'((sum2 >= {1'b0, size}) ? sum2 - {1'b0, size} : sum2);
        probe_cnt <= probe_cnt - 1'b1;
      end
      if (cmd.slot_read) len_rd <= len_mem[slot[shtqp_pkg::SLOT_W-1:0]];
      if (cmd.cmp_init) ci <= '0;
      else if (cmd.cmp_step || cmd.write_step) ci <= ci + 1'b1;
      if (cmd.write_step) begin
        if (ci == '0) begin
          used[slot[shtqp_pkg::SLOT_W-1:0]] <= 1'b1;
          len_mem[slot[shtqp_pkg::SLOT_W-1:0]] <= qlen;
        end
        if (ci < qlen)
          key_mem[key_addr] <= query[ci[shtqp_pkg::QIDX_W-1:0]];
      end
      key_rd <= key_mem[key_addr];
      if (cmd.clear_query) begin
        hash <= '0;
        qlen <= '0;
      end
    end
  end

  assign stat.last = last_hold;
  assign stat.op = op_hold;
  assign stat.too_long = qlen > shtqp_pkg::LEN_W'(shtqp_pkg::MAX_KEY_LEN);
  assign stat.mod_done = (mod_cnt == 6'd0);
  assign stat.probes_left = (probe_cnt != 9'd0);
  assign stat.used = used[slot[shtqp_pkg::SLOT_W-1:0]];
  assign stat.len_match = (len_rd == qlen);
  assign stat.cmp_left = (ci < qlen);
  assign stat.char_match = (key_rd == query[ci[shtqp_pkg::QIDX_W-1:0] - 1'b1]);
  assign stat.write_left = (ci < qlen);
  assign slot_out = slot[7:0];
endmodule

// ===== sv/shtqp_ctrl.sv =====
// Controller state machine sequencing accumulate, hash reduce and probing.
`timescale 1ns / 1ps
module shtqp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  shtqp_pkg::stat_t  stat,
  output shtqp_pkg::cmd_t   cmd,
  output logic              done,
  output logic [2:0]        res_status,
  output logic              res_zero
);
  shtqp_pkg::state_t state, state_next;
  logic [2:0] st_reg, st_next;
  logic zero_reg, zero_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shtqp_pkg::S_IDLE;
      st_reg <= '0;
      zero_reg <= 1'b1;
    end else begin
      state <= state_next;
      st_reg <= st_next;
      zero_reg <= zero_next;
    end
  end

  always_comb begin
    state_next = state;
    st_next = st_reg;
    zero_next = zero_reg;
    cmd = '0;
    busy = (state != shtqp_pkg::S_IDLE);
    done = 1'b0;
    case (state)
      shtqp_pkg::S_IDLE: if (start) begin
        cmd.acc_char = 1'b1;
        state_next = shtqp_pkg::S_MUL;
      end
      shtqp_pkg::S_MUL: begin
        cmd.acc_mul = 1'b1;
        state_next = shtqp_pkg::S_ACC;
      end
      shtqp_pkg::S_ACC: begin
        cmd.acc_add = 1'b1;
        if (!stat.last) state_next = shtqp_pkg::S_IDLE;
        else if (stat.too_long) begin
          st_next = shtqp_pkg::ST_TOO_LONG;
          zero_next = 1'b1;
          state_next = shtqp_pkg::S_DONE;
        end else state_next = shtqp_pkg::S_MOD;
      end
      shtqp_pkg::S_MOD: begin
        cmd.mod_start = 1'b1;
        state_next = shtqp_pkg::S_PROBE;
      end
      shtqp_pkg::S_PROBE: if (stat.mod_done) begin
        cmd.probe_init = 1'b1;
        state_next = shtqp_pkg::S_READ;
      end
      shtqp_pkg::S_READ: begin
        cmd.slot_read = 1'b1;
        cmd.cmp_init = 1'b1;
        state_next = shtqp_pkg::S_CHECK;
      end
      shtqp_pkg::S_CHECK: begin
        if (!stat.probes_left) begin
          st_next = stat.op ? shtqp_pkg::ST_NOT_FOUND : shtqp_pkg::ST_FULL;
          zero_next = 1'b1;
          state_next = shtqp_pkg::S_DONE;
        end else if (!stat.used) begin
          if (stat.op) begin
            st_next = shtqp_pkg::ST_NOT_FOUND;
            zero_next = 1'b1;
            state_next = shtqp_pkg::S_DONE;
          end else state_next = shtqp_pkg::S_WRITE;
        end else if (stat.op && stat.len_match) begin
          cmd.cmp_step = 1'b1;
          state_next = shtqp_pkg::S_CMP;
        end else state_next = shtqp_pkg::S_NEXT;
      end
      // key data is read through a register, so it trails the char index
      shtqp_pkg::S_CMP: begin
        if (!stat.char_match) state_next = shtqp_pkg::S_NEXT;
        else if (!stat.cmp_left) begin
          st_next = shtqp_pkg::ST_FOUND;
          zero_next = 1'b0;
          state_next = shtqp_pkg::S_DONE;
        end else cmd.cmp_step = 1'b1;
      end
      shtqp_pkg::S_WRITE: begin
        cmd.write_step = 1'b1;
        if (!stat.write_left) begin
          st_next = shtqp_pkg::ST_INSERTED;
          zero_next = 1'b0;
          state_next = shtqp_pkg::S_DONE;
        end
      end
      shtqp_pkg::S_NEXT: begin
        cmd.probe_step = 1'b1;
        state_next = shtqp_pkg::S_READ;
      end
      shtqp_pkg::S_DONE: begin
        done = 1'b1;
        cmd.clear_query = 1'b1;
        state_next = shtqp_pkg::S_IDLE;
      end
      default: state_next = shtqp_pkg::S_IDLE;
    endcase
  end

  assign res_status = st_reg;
  assign res_zero = zero_reg;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> state == shtqp_pkg::S_IDLE) else $error("done not followed by idle");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    done |-> stat.last) else $error("result without final char");
endmodule

// ===== sv/string_hash_table_quadratic_probe.sv =====
// Top level: string hash table with triangular probing.
// Non-final char: busy for multiply and accumulate after accept; next request once idle again.
// Final char: multiply, accumulate, bit-serial modulo, read/check/next per probed slot, a compare
// step per char on a length match, insert writes; then done, result strobe the cycle after.
// One request at a time; result strobe lasts one cycle and cannot be stalled.
// Synchronous reset clears the occupancy bits at once, table_size 256, multiplier 31.
`timescale 1ns / 1ps
module string_hash_table_quadratic_probe (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [6:0]  key_char,
  input  logic        last_char,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [7:0]  slot_index
);
  logic [8:0] table_size;
  logic [31:0] hash_multiplier;
  shtqp_pkg::cmd_t cmd;
  shtqp_pkg::stat_t stat;
  logic done, res_zero;
  logic [2:0] res_status;
  logic [7:0] slot_out;

  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= 9'd256;
      hash_multiplier <= 32'd31;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index == shtqp_pkg::CFG_TABLE_SIZE)
        table_size <= cfg_data[8:0];
      if (cfg_valid && cfg_ready && cfg_index == shtqp_pkg::CFG_HASH_MULT)
        hash_multiplier <= cfg_data;
      result_valid <= done;
      if (done) begin
        status <= res_status;
        slot_index <= res_zero ? 8'd0 : slot_out;
      end
    end
  end

  shtqp_ctrl u_ctrl (.clk, .rst, .start, .busy, .stat, .cmd, .done, .res_status, .res_zero);
  shtqp_datapath u_dp (.clk, .rst, .table_size, .hash_multiplier, .op, .key_char,
    .last_char, .cmd, .stat, .slot_out);
endmodule
